// File: rtl/core/b64sc_pkg.sv
package b64sc_pkg;

    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SLASH_CHAR = 8'h2F;

    localparam logic [2:0] MAX_BEATS = 3'd4;

    // partial group held between items
    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  count;
        logic        third_pad;
    } t_group;

    // result beats that one item produces, first beat in the top byte
    typedef struct packed {
        logic [31:0] bytes;
        logic [2:0]  count;
        logic        stream_end;
        logic        err;
    } t_burst;

    function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] c;
        w = {2'b00, v};
        if (w < 8'd26) begin
            c = 8'h41 + w;
        end else if (w < 8'd52) begin
            c = 8'h61 + (w - 8'd26);
        end else if (w < 8'd62) begin
            c = 8'h30 + (w - 8'd52);
        end else if (w == 8'd62) begin
            c = PLUS_CHAR;
        end else begin
            c = SLASH_CHAR;
        end
        return c;
    endfunction

    function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'h41 && c <= 8'h5A) begin
            v = c - 8'h41;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            v = c - 8'h61 + 8'd26;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30 + 8'd52;
        end else if (c == PLUS_CHAR) begin
            v = 8'd62;
        end else if (c == SLASH_CHAR) begin
            v = 8'd63;
        end else begin
            v = 8'd0;
        end
        return v[5:0];
    endfunction

endpackage

// File: rtl/core/b64sc_step.sv
module b64sc_step (
    input  logic               i_decode_mode,
    input  b64sc_pkg::t_group  i_group,
    input  logic [7:0]         i_in_byte,
    input  logic               i_in_last,
    output b64sc_pkg::t_group  o_group,
    output b64sc_pkg::t_burst  o_burst
);

    logic [2:0]  cnt;
    logic [23:0] enc_bits;
    logic [23:0] trip;
    logic [2:0]  nchar;
    logic [23:0] dec_bits;
    logic        is_pad;
    logic [5:0]  sx;
    logic [2:0]  nbytes;

    assign cnt = {1'b0, i_group.count} + 3'd1;
    assign enc_bits = {i_group.bits[15:0], i_in_byte};
    assign is_pad = (i_in_byte == b64sc_pkg::PAD_CHAR);
    assign sx = is_pad ? 6'd0 : b64sc_pkg::char_to_sextet(i_in_byte);
    assign dec_bits = {i_group.bits[17:0], sx};
    assign nbytes = 3'd3 - {2'b00, i_in_last & is_pad} - {2'b00, i_in_last & i_group.third_pad};

    always_comb begin
        // left-align a short final group so the sextets come out in order
        if (cnt == 3'd3) begin
            trip  = enc_bits;
            nchar = 3'd4;
        end else if (cnt == 3'd1) begin
            trip  = {i_in_byte, 16'h0000};
            nchar = 3'd2;
        end else begin
            trip  = {enc_bits[15:0], 8'h00};
            nchar = 3'd3;
        end
    end

    always_comb begin
        o_group = i_group;
        o_burst = '0;
        if (!i_decode_mode) begin
            if (cnt == 3'd3 || i_in_last) begin
                for (int i = 0; i < 4; i++) begin
                    o_burst.bytes[31-8*i -: 8] = (3'(i) < nchar)
                        ? b64sc_pkg::sextet_to_char(trip[23-6*i -: 6])
                        : b64sc_pkg::PAD_CHAR;
                end
                o_burst.count      = b64sc_pkg::MAX_BEATS;
                o_burst.stream_end = i_in_last;
                o_group            = '0;
            end else begin
                o_group.bits  = enc_bits;
                o_group.count = cnt[1:0];
            end
        end else begin
            if (cnt == 3'd4) begin
                o_burst.bytes      = {dec_bits, 8'h00};
                o_burst.count      = nbytes;
                o_burst.stream_end = i_in_last;
                o_group            = '0;
            end else if (i_in_last) begin
                // short stream: one zero beat flagged as a length error
                o_burst.count      = 3'd1;
                o_burst.stream_end = 1'b1;
                o_burst.err        = 1'b1;
                o_group            = '0;
            end else begin
                o_group.bits      = dec_bits;
                o_group.count     = cnt[1:0];
                o_group.third_pad = i_group.third_pad | ((cnt == 3'd3) & is_pad);
            end
        end
    end

endmodule

// File: rtl/core/base64_stream_codec.sv
// Streaming Base64 codec, standard alphabet with '=' padding. i_cfg_data
// written with i_cfg_we selects encoding (0) or decoding (1) and drops any
// partial group; write it only while no beat is in flight. Each input beat
// updates the group state and loads its results, up to four beats, into an
// output buffer that drains one beat per cycle while i_ready is high. A new
// beat is taken while the buffer is empty or on the cycle its last beat
// leaves, so the output buffer sets the rate.
module base64_stream_codec (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_stream_end,
    output logic       o_length_error
);

    logic              r_mode;
    b64sc_pkg::t_group r_grp;
    b64sc_pkg::t_group n_grp;
    b64sc_pkg::t_burst n_burst;
    logic [31:0]       r_buf;
    logic [2:0]        r_cnt;
    logic              r_end;
    logic              r_err;
    logic              in_beat;
    logic              out_beat;

    b64sc_step u_step (
        .i_decode_mode (r_mode),
        .i_group       (r_grp),
        .i_in_byte     (i_in_byte),
        .i_in_last     (i_in_last),
        .o_group       (n_grp),
        .o_burst       (n_burst)
    );

    assign o_valid        = (r_cnt != 3'd0);
    assign o_ready        = (r_cnt == 3'd0) || (r_cnt == 3'd1 && i_ready);
    assign in_beat        = i_valid && o_ready;
    assign out_beat       = o_valid && i_ready;
    assign o_out_byte     = r_buf[31:24];
    assign o_run_last     = (r_cnt == 3'd1);
    assign o_stream_end   = (r_cnt == 3'd1) && r_end;
    assign o_length_error = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_grp  <= '0;
            r_cnt  <= 3'd0;
            r_end  <= 1'b0;
            r_err  <= 1'b0;
        end else begin
            if (in_beat && !i_cfg_we && n_burst.count != 3'd0) begin
                r_cnt <= n_burst.count;
            end else if (out_beat) begin
                r_cnt <= r_cnt - 3'd1;
            end
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
                r_grp  <= '0;
            end else if (in_beat) begin
                r_grp <= n_grp;
                if (n_burst.count != 3'd0) begin
                    r_end <= n_burst.stream_end;
                    r_err <= n_burst.err;
                end
            end
        end
    end

    // payload shift register, no reset
    always_ff @(posedge i_clk) begin
        if (in_beat && !i_cfg_we && n_burst.count != 3'd0) begin
            r_buf <= n_burst.bytes;
        end else if (out_beat) begin
            r_buf <= {r_buf[23:0], 8'h00};
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= b64sc_pkg::MAX_BEATS)
        else $error("output buffer count out of range");

    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_length_error) |->
            (o_out_byte == 8'h00 && o_run_last && o_stream_end))
        else $error("length error beat malformed");

    a_take_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_ready) |-> (o_run_last && i_ready))
        else $error("input taken while buffer still holds beats");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_end) |-> (r_grp.count == 2'd0 && !r_grp.third_pad))
        else $error("group state left over at stream end");

endmodule
